// ----- rtl/pbm_pkg.sv -----
// Shared constants and types for the pixel blend modes block.
// Holds channel width, mode codes, lane post-operation codes and lane control.
// No dependencies.
package pbm_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int LANE_STAGES  = 5;
  localparam int MODE_BITS    = 3;

  localparam logic [CHANNEL_BITS-1:0]   CH_MAX    = {CHANNEL_BITS{1'b1}};
  localparam logic [2*CHANNEL_BITS-1:0] CH_MAX_SQ =
    (2*CHANNEL_BITS)'(CH_MAX) * (2*CHANNEL_BITS)'(CH_MAX);

  localparam logic [MODE_BITS-1:0] MODE_NORMAL   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_MULTIPLY = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ADD      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DIFF     = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_OVERLAY  = 3'd4;

  // What to do with the first product to get the blended color at scale M*M
  typedef enum logic [1:0] {
    POST_PASS       = 2'd0,
    POST_DOUBLE     = 2'd1,
    POST_INV_DOUBLE = 2'd2
  } post_t;

  // Per-stage load strobes shared by all lanes
  typedef struct packed {
    logic [LANE_STAGES-1:0] adv;
  } lane_ctl_t;

endpackage

// ----- rtl/pixel_blend_modes.sv -----
// Pixel blend modes block: three channel lanes, valid pipeline and output merge.
// An accepted item loads the first lane stage, then moves through four more lane stages
// and the output register. Throughput: one item per cycle unless out_ready stalls;
// a stage advances when it is empty or the next one does.
// Reset (rst_n low, synchronous) empties the pipeline and sets the mode to normal.
// Depends on pbm_pkg and pbm_lane.
module pixel_blend_modes (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [pbm_pkg::MODE_BITS-1:0]         cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_src_red,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_src_green,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_src_blue,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_src_alpha,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_dest_red,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_dest_green,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]      in_dest_blue,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pbm_pkg::CHANNEL_BITS-1:0]      out_red,
  output logic [pbm_pkg::CHANNEL_BITS-1:0]      out_green,
  output logic [pbm_pkg::CHANNEL_BITS-1:0]      out_blue,
  output logic [pbm_pkg::CHANNEL_BITS-1:0]      out_alpha
);

  localparam int NS = pbm_pkg::LANE_STAGES;
  localparam int W  = pbm_pkg::CHANNEL_BITS;

  // Mode register: the user must write it only while the block is idle; the block does not enforce this.
  logic [pbm_pkg::MODE_BITS-1:0] mode_r;
  logic [pbm_pkg::MODE_BITS-1:0] mode_nxt;

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pbm_pkg::MODE_NORMAL;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Valid bit per lane stage plus the output register.
  logic [NS-1:0] stg_vld_r;
  logic [NS-1:0] stg_vld_nxt;
  logic          out_vld_r;
  logic          out_vld_nxt;
  logic [NS:0]   load;

  // Load strobes run back from the output: a stage loads when it is empty
  // or when the stage after it loads this cycle.
  always_comb begin
    load[NS] = !out_vld_r || out_ready;
    for (int k = NS-1; k >= 0; k--) begin
      load[k] = !stg_vld_r[k] || load[k+1];
    end
  end

  always_comb begin
    stg_vld_nxt[0] = load[0] ? in_valid : stg_vld_r[0];
    for (int k = 1; k < NS; k++) begin
      stg_vld_nxt[k] = load[k] ? stg_vld_r[k-1] : stg_vld_r[k];
    end
    out_vld_nxt = load[NS] ? stg_vld_r[NS-1] : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready = load[0];

  // All three lanes step together under one set of strobes.
  pbm_pkg::lane_ctl_t lane_ctl;
  assign lane_ctl.adv = load[NS-1:0];

  logic [W-1:0] res_red;
  logic [W-1:0] res_green;
  logic [W-1:0] res_blue;

  pbm_lane u_lane_red (
    .clk   (clk),
    .ctl   (lane_ctl),
    .mode  (mode_r),
    .src   (in_src_red),
    .dst   (in_dest_red),
    .alpha (in_src_alpha),
    .res   (res_red)
  );

  pbm_lane u_lane_green (
    .clk   (clk),
    .ctl   (lane_ctl),
    .mode  (mode_r),
    .src   (in_src_green),
    .dst   (in_dest_green),
    .alpha (in_src_alpha),
    .res   (res_green)
  );

  pbm_lane u_lane_blue (
    .clk   (clk),
    .ctl   (lane_ctl),
    .mode  (mode_r),
    .src   (in_src_blue),
    .dst   (in_dest_blue),
    .alpha (in_src_alpha),
    .res   (res_blue)
  );

  // Merge: gather the lane results into one output item; hold while stalled.
  logic [W-1:0] red_r;
  logic [W-1:0] green_r;
  logic [W-1:0] blue_r;

  always_ff @(posedge clk) begin
    if (load[NS]) begin
      red_r   <= res_red;
      green_r <= res_green;
      blue_r  <= res_blue;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  // Result is always fully opaque.
  assign out_alpha = pbm_pkg::CH_MAX;

  // An accepted item always lands in the first lane stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stg_vld_r[0])
    else $error("accepted item did not enter the lane pipeline");

  // The last lane stage must not drop its item while the output is stalled.
  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r[NS-1] && out_vld_r && !out_ready |=> stg_vld_r[NS-1])
    else $error("item lost from last lane stage under stall");

  // Input back-pressure only when every slot in the pipeline is occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&stg_vld_r) && out_vld_r && !out_ready)
    else $error("input stalled with a free pipeline slot");

  // A delivered result leaves the output empty unless a new one moves up.
  a_out_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ready && !stg_vld_r[NS-1] |=> !out_vld_r)
    else $error("output valid without an item behind it");

endmodule

// ----- rtl/pbm_lane.sv -----
// One color channel lane of the pixel blend pipeline: blend, alpha mix, divide.
// Depends on pbm_pkg. Stage loads come from the top level as a lane_ctl_t.
module pbm_lane (
  input  logic                                 clk,
  input  pbm_pkg::lane_ctl_t                   ctl,
  input  logic [pbm_pkg::MODE_BITS-1:0]        mode,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]     src,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]     dst,
  input  logic [pbm_pkg::CHANNEL_BITS-1:0]     alpha,
  output logic [pbm_pkg::CHANNEL_BITS-1:0]     res
);

  localparam int W  = pbm_pkg::CHANNEL_BITS;
  localparam int RW = 2*W + 2;
  localparam logic [RW-1:0] SQ_X1 = RW'(pbm_pkg::CH_MAX_SQ);
  localparam logic [RW-1:0] SQ_X2 = RW'(pbm_pkg::CH_MAX_SQ) << 1;

  // stage 1: operand select and products
  logic [W:0]          sum_w;
  logic [W-1:0]        sat_sum;
  logic [W-1:0]        abs_diff;
  logic                dst_low;
  logic [W-1:0]        op_x;
  logic [W-1:0]        op_y;
  pbm_pkg::post_t      post_sel;
  logic [2*W-1:0]      prod_nxt;
  logic [2*W-1:0]      dinv_nxt;
  logic [2*W-1:0]      prod_r;
  logic [2*W-1:0]      dinv1_r;
  logic [W-1:0]        alpha1_r;
  pbm_pkg::post_t      post1_r;

  always_comb begin
    sum_w    = {1'b0, src} + {1'b0, dst};
    sat_sum  = (sum_w > {1'b0, pbm_pkg::CH_MAX}) ? pbm_pkg::CH_MAX : sum_w[W-1:0];
    abs_diff = (dst > src) ? (dst - src) : (src - dst);
    dst_low  = {dst, 1'b0} < {1'b0, pbm_pkg::CH_MAX};
    op_x     = dst;
    op_y     = pbm_pkg::CH_MAX;
    post_sel = pbm_pkg::POST_PASS;
    case (mode)
      pbm_pkg::MODE_NORMAL: begin
        op_x = src;
      end
      pbm_pkg::MODE_MULTIPLY: begin
        op_x = src;
        op_y = dst;
      end
      pbm_pkg::MODE_ADD: begin
        op_x = sat_sum;
      end
      pbm_pkg::MODE_DIFF: begin
        op_x = abs_diff;
      end
      pbm_pkg::MODE_OVERLAY: begin
        if (dst_low) begin
          op_x     = src;
          op_y     = dst;
          post_sel = pbm_pkg::POST_DOUBLE;
        end else begin
          op_x     = pbm_pkg::CH_MAX - src;
          op_y     = pbm_pkg::CH_MAX - dst;
          post_sel = pbm_pkg::POST_INV_DOUBLE;
        end
      end
      default: begin
        // unused codes pass the destination through
        op_x = dst;
      end
    endcase
    prod_nxt = (2*W)'(op_x) * (2*W)'(op_y);
    dinv_nxt = (2*W)'(dst) * (2*W)'(pbm_pkg::CH_MAX - alpha);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      prod_r   <= prod_nxt;
      dinv1_r  <= dinv_nxt;
      alpha1_r <= alpha;
      post1_r  <= post_sel;
    end
  end

  // stage 2: blended color at scale M*M, weight by alpha
  logic [2*W-1:0] blend;
  logic [2*W-1:0] prod_dbl;
  logic [3*W-1:0] wsrc_nxt;
  logic [3*W-1:0] wsrc_r;
  logic [2*W-1:0] dinv2_r;

  always_comb begin
    prod_dbl = {prod_r[2*W-2:0], 1'b0};
    case (post1_r)
      pbm_pkg::POST_PASS:       blend = prod_r;
      pbm_pkg::POST_DOUBLE:     blend = prod_dbl;
      pbm_pkg::POST_INV_DOUBLE: blend = pbm_pkg::CH_MAX_SQ - prod_dbl;
      default:                  blend = prod_r;
    endcase
    wsrc_nxt = (3*W)'(blend) * (3*W)'(alpha1_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      wsrc_r  <= wsrc_nxt;
      dinv2_r <= dinv1_r;
    end
  end

  // stage 3: numerator; d*(M-a)*M as shift minus
  logic [3*W-1:0] num_nxt;
  logic [3*W-1:0] num_r;

  assign num_nxt = wsrc_r + ((3*W)'(dinv2_r) << W) - (3*W)'(dinv2_r);

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      num_r <= num_nxt;
    end
  end

  // stage 4: estimate quotient by 2^(2W), remainder against M*M
  logic [W-1:0]  quo_est;
  logic [RW-1:0] rem_nxt;
  logic [W-1:0]  quo_est_r;
  logic [RW-1:0] rem_r;

  assign quo_est = num_r[3*W-1:2*W];
  assign rem_nxt = RW'(num_r[2*W-1:0]) + (RW'(quo_est) << (W+1)) - RW'(quo_est);

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      quo_est_r <= quo_est;
      rem_r     <= rem_nxt;
    end
  end

  // stage 5: estimate is low by at most two
  logic [W-1:0] res_nxt;
  logic [W-1:0] res_r;

  assign res_nxt = quo_est_r + W'(rem_r >= SQ_X1) + W'(rem_r >= SQ_X2);

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- bench/tb_pixel_blend_modes.sv -----
// Self-checking bench for pixel_blend_modes: every pixel result is checked against
// an in-bench blend predictor, under all mode codes and several flow-control profiles.
// Depends on pbm_pkg and the pixel_blend_modes RTL.
`timescale 1ns / 100ps

module tb_pixel_blend_modes;

  localparam int CB           = pbm_pkg::CHANNEL_BITS;
  localparam int MB           = pbm_pkg::MODE_BITS;
  // Item accepted to result valid, used by drain() as settling margin
  localparam int PIPE_LATENCY = 5;
  localparam int LONG_STALL   = 60;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 10;

  // One accepted input item: source RGBA over destination RGB
  typedef struct {
    logic [CB-1:0] src_red;
    logic [CB-1:0] src_green;
    logic [CB-1:0] src_blue;
    logic [CB-1:0] src_alpha;
    logic [CB-1:0] dest_red;
    logic [CB-1:0] dest_green;
    logic [CB-1:0] dest_blue;
  } pixel_pair_t;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic [CB-1:0] alpha;
  } rgba_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [MB-1:0]        cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CB-1:0]        in_src_red = '0;
  logic [CB-1:0]        in_src_green = '0;
  logic [CB-1:0]        in_src_blue = '0;
  logic [CB-1:0]        in_src_alpha = '0;
  logic [CB-1:0]        in_dest_red = '0;
  logic [CB-1:0]        in_dest_green = '0;
  logic [CB-1:0]        in_dest_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CB-1:0]        out_red;
  logic [CB-1:0]        out_green;
  logic [CB-1:0]        out_blue;
  logic [CB-1:0]        out_alpha;

  pixel_pair_t          pending_pixels[$];   // items waiting to be offered
  rgba_t                awaited_pixels[$];   // predicted results, oldest first
  logic [MB-1:0]        active_mode = pbm_pkg::MODE_NORMAL;

  int  queued_count   = 0;
  int  accepted_count = 0;
  int  fail_count     = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  stall_req      = 0;     // bumped to request one long receiver hold-off
  bit  sender_hold    = 1'b0;
  bit  in_taken       = 1'b0;  // item on the input port was accepted at last rising edge

  pixel_blend_modes i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .in_dest_red  (in_dest_red),
    .in_dest_green(in_dest_green),
    .in_dest_blue (in_dest_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #2_000_000;
    $display("** pixel_blend_modes: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact unorm math. The blended color b sits at scale M*M, then
  // gets mixed with the destination by alpha and truncated back to a byte.
  // ---------------------------------------------------------------------------
  function automatic logic [CB-1:0] blend_channel(input logic [CB-1:0] s,
                                                  input logic [CB-1:0] d,
                                                  input logic [CB-1:0] a,
                                                  input logic [MB-1:0] mode);
    int unsigned m, si, di, ai, b, num;
    m  = pbm_pkg::CH_MAX;
    si = s;
    di = d;
    ai = a;
    case (mode)
      pbm_pkg::MODE_NORMAL:   b = si * m;
      pbm_pkg::MODE_MULTIPLY: b = si * di;
      pbm_pkg::MODE_ADD:      b = ((si + di > m) ? m : si + di) * m;
      pbm_pkg::MODE_DIFF:     b = ((di > si) ? di - si : si - di) * m;
      pbm_pkg::MODE_OVERLAY: begin
        // dark destination doubles the product, bright one takes the screen form
        if (2 * di < m) b = 2 * si * di;
        else            b = m * m - 2 * (m - si) * (m - di);
      end
      default:       b = di * m;  // unused codes pass the destination through
    endcase
    num = b * ai + di * m * (m - ai);
    return CB'(num / (m * m));
  endfunction

  function automatic rgba_t blend_pixel(input pixel_pair_t p,
                                        input logic [MB-1:0] mode);
    rgba_t r;
    r.red   = blend_channel(p.src_red,   p.dest_red,   p.src_alpha, mode);
    r.green = blend_channel(p.src_green, p.dest_green, p.src_alpha, mode);
    r.blue  = blend_channel(p.src_blue,  p.dest_blue,  p.src_alpha, mode);
    r.alpha = pbm_pkg::CH_MAX;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge, hold an offered item until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : pixel_driver
    pixel_pair_t nxt;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold: item still waiting for ready
    end else begin
      offer = pending_pixels.size() > 0 && !sender_hold &&
              ($urandom_range(99) >= send_idle_pct);
      if (offer) begin
        nxt = pending_pixels.pop_front();
        in_src_red    <= nxt.src_red;
        in_src_green  <= nxt.src_green;
        in_src_blue   <= nxt.src_blue;
        in_src_alpha  <= nxt.src_alpha;
        in_dest_red   <= nxt.dest_red;
        in_dest_green <= nxt.dest_green;
        in_dest_blue  <= nxt.dest_blue;
      end
      in_valid <= offer;
    end
  end

  // Result side ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : result_receiver
    int stall_left;
    int stall_served;
    if (stall_req != stall_served) begin
      stall_served = stall_req;
      stall_left   = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. Check results against
  // the oldest prediction, then record a prediction for any accepted item.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_monitor
    pixel_pair_t taken;
    rgba_t       got;
    rgba_t       want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_alpha};
        if (awaited_pixels.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d", $realtime,
                   got.red, got.green, got.blue, got.alpha);
          fail_count++;
        end else begin
          want = awaited_pixels.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d,",
                      " got r=%0d g=%0d b=%0d a=%0d"},
                     $realtime, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
            fail_count++;
          end
        end
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken.src_red    = in_src_red;
        taken.src_green  = in_src_green;
        taken.src_blue   = in_src_blue;
        taken.src_alpha  = in_src_alpha;
        taken.dest_red   = in_dest_red;
        taken.dest_green = in_dest_green;
        taken.dest_blue  = in_dest_blue;
        awaited_pixels = {awaited_pixels, blend_pixel(taken, active_mode)};
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pixel(input logic [CB-1:0] sr, sg, sb, sa, dr, dg, db);
    pixel_pair_t p;
    p.src_red    = sr;
    p.src_green  = sg;
    p.src_blue   = sb;
    p.src_alpha  = sa;
    p.dest_red   = dr;
    p.dest_green = dg;
    p.dest_blue  = db;
    pending_pixels = {pending_pixels, p};
    queued_count++;
  endtask

  // Bias toward the extremes and the overlay threshold around one half
  function automatic logic [CB-1:0] pick_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return pbm_pkg::CH_MAX;
      2:       return pbm_pkg::CH_MAX >> 1;
      3:       return (pbm_pkg::CH_MAX >> 1) + 1;
      default: return CB'($urandom_range(pbm_pkg::CH_MAX));
    endcase
  endfunction

  task automatic queue_random(input int count);
    repeat (count) begin
      queue_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                  pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  // Wait until every queued item is accepted and every result has come back
  task automatic drain();
    while (accepted_count != queued_count || awaited_pixels.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Only call while the block is empty
  task automatic write_mode(input logic [MB-1:0] mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    active_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_profile(input int profile);
    case (profile)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    int mark;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: three corner pixels under every mode code, unused ones included.
    // Covers black over white, alpha zero, add saturation,
    // difference both ways and both sides of the overlay threshold.
    for (int m = 0; m < (1 << MB); m++) begin
      write_mode(MB'(m));
      queue_pixel('0, '0, '0, pbm_pkg::CH_MAX, pbm_pkg::CH_MAX, 8'd127, 8'd128);
      queue_pixel(pbm_pkg::CH_MAX, pbm_pkg::CH_MAX, pbm_pkg::CH_MAX, '0, '0,
                  pbm_pkg::CH_MAX, 8'd1);
      queue_pixel(8'd200, 8'd100, pbm_pkg::CH_MAX, 8'd128, 8'd127, 8'd200, '0);
      drain();
    end

    // Random phases, each under its own mode and flow-control profile
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(MB'((ph * 3 + 4) % (1 << MB)));
      set_profile(ph % 4);
      if (ph == 0) begin
        // Fill the pipe against a stalled receiver so in_ready drops
        queue_random(PHASE_ITEMS / 2);
        @(negedge clk);
        stall_req = stall_req + 1;
        // Then pause the sender mid-stream until every result is back
        mark = queued_count;
        queue_random(PHASE_ITEMS / 2);
        while (accepted_count < mark + 15) @(negedge clk);
        sender_hold = 1'b1;
        while (awaited_pixels.size() != 0 || in_valid) @(negedge clk);
        sender_hold = 1'b0;
      end else begin
        queue_random(PHASE_ITEMS);
      end
      drain();
    end

    if (fail_count == 0 && awaited_pixels.size() == 0) begin
      $display("** pixel_blend_modes: PASSED **");
    end else begin
      $display("** pixel_blend_modes: FAILED **");
    end
    $finish;
  end

endmodule
